### hdl/i2cbd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// I2C baud divider search package
// Shared widths, search limits and the request and response types of the
// bit-serial divider.
// ----------------------------------------------------------------------------
package i2cbd_pkg;

  localparam int unsigned RATE_W = 22;
  localparam int unsigned CLK_W  = 32;
  localparam int unsigned DIV_W  = 16;
  localparam int unsigned SCL_W  = 3;
  localparam int unsigned PROD_W = 27;
  localparam int unsigned CNT_W  = 5;

  localparam logic [3:0] SCL_FIRST = 4'd9;
  localparam logic [3:0] SCL_LAST  = 4'd2;

  typedef struct packed {
    logic              start;
    logic [CLK_W-1:0]  dividend;
    logic [PROD_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [CLK_W-1:0]  quotient;
    logic [PROD_W-1:0] remainder;
  } div_rsp_t;

endpackage
`default_nettype wire

### hdl/i2cbd_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// I2C baud divider search channels
// Valid/ready channels for the request beat and the result beat.
// ----------------------------------------------------------------------------
interface i2cbd_in_if;
  logic                       valid;
  logic                       ready;
  logic [i2cbd_pkg::RATE_W-1:0] bit_rate;
  logic [i2cbd_pkg::CLK_W-1:0]  source_clock;

  modport source (output valid, output bit_rate, output source_clock, input ready);
  modport sink   (input valid, input bit_rate, input source_clock, output ready);
endinterface

interface i2cbd_out_if;
  logic                        valid;
  logic                        ready;
  logic [i2cbd_pkg::DIV_W-1:0] divider_field;
  logic [i2cbd_pkg::SCL_W-1:0] scl_time_field;
  logic [i2cbd_pkg::CLK_W-1:0] residual_error;

  modport source (output valid, output divider_field, output scl_time_field,
                  output residual_error, input ready);
  modport sink   (input valid, input divider_field, input scl_time_field,
                  input residual_error, output ready);
endinterface
`default_nettype wire

### hdl/i2cbd_serial_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// I2C baud divider search: bit-serial divider
// Restoring division producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module i2cbd_serial_div (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire i2cbd_pkg::div_req_t req,
  output i2cbd_pkg::div_rsp_t      rsp
);

  localparam int unsigned CW = i2cbd_pkg::CLK_W;
  localparam int unsigned PW = i2cbd_pkg::PROD_W;
  localparam int unsigned NW = i2cbd_pkg::CNT_W;

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] quo_r, quo_nxt;
  logic [PW-1:0] rem_r, rem_nxt;
  logic [PW-1:0] dvs_r, dvs_nxt;
  logic [PW:0]   shifted;
  logic [PW+1:0] diff;

  assign shifted = {rem_r, quo_r[CW-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      if (!diff[PW+1]) begin
        rem_nxt = diff[PW-1:0];
        quo_nxt = {quo_r[CW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[PW-1:0];
        quo_nxt = {quo_r[CW-2:0], 1'b0};
      end
      if (cnt_r == NW'(CW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + NW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

`ifndef ASSERT_OFF
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("Division started while the divider was busy.");
  a_last_step_done: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !req.start && cnt_r == NW'(CW - 1)) |=> (done_r && !busy_r))
    else $error("Divider did not finish after its last step.");
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("Divider flagged done while still busy.");
`endif

endmodule
`default_nettype wire

### hdl/i2c_baud_divider_search.sv
`default_nettype none
// Each SCL count tried passes through the start, run and evaluate states; the
// search then ends in the final state, which raises the result beat's valid.
// A new request is taken only in idle, after the last result beat is registered;
// a result beat still waiting for ready holds the search in its final step.
// Reset (synchronous, active low) returns the sequencer to idle and drops the
// result beat's valid.
// ----------------------------------------------------------------------------
// I2C baud divider search
// Tries SCL half-period counts from nine down to two, stopping at a zero error
// or oversized quotient, and keeps the divider of lowest residual clock error.
// ----------------------------------------------------------------------------
module i2c_baud_divider_search (
  input  wire logic   clk,
  input  wire logic   rst_n,
  i2cbd_in_if.sink    in_ch,
  i2cbd_out_if.source out_ch
);

  localparam int unsigned RW = i2cbd_pkg::RATE_W;
  localparam int unsigned CW = i2cbd_pkg::CLK_W;
  localparam int unsigned DW = i2cbd_pkg::DIV_W;
  localparam int unsigned PW = i2cbd_pkg::PROD_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_START = 3'd1;
  localparam logic [2:0] ST_RUN   = 3'd2;
  localparam logic [2:0] ST_EVAL  = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [3:0]    scl_r, scl_nxt;
  logic          have_r, have_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [RW-1:0] rate_r, rate_nxt;
  logic [CW-1:0] clk_r, clk_nxt;
  logic [PW-1:0] prod_r, prod_nxt;
  logic [DW-1:0] best_div_r, best_div_nxt;
  logic [3:0]    kept_scl_r, kept_scl_nxt;
  logic [CW-1:0] best_err_r, best_err_nxt;
  logic [DW-1:0] out_div_r, out_div_nxt;
  logic [i2cbd_pkg::SCL_W-1:0] out_scl_r, out_scl_nxt;
  logic [CW-1:0] out_err_r, out_err_nxt;

  logic          accept;
  logic          q_big;
  logic [DW-1:0] div_v;
  logic [CW-1:0] err_v;
  logic          out_free;

  i2cbd_pkg::div_req_t div_req;
  i2cbd_pkg::div_rsp_t div_rsp;

  i2cbd_serial_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  assign div_req.start    = (state_r == ST_START);
  assign div_req.dividend = clk_r;
  assign div_req.divisor  = prod_r;

  assign q_big = (div_rsp.quotient[CW-1:DW] != '0);
  assign div_v = q_big ? '0 : div_rsp.quotient[DW-1:0];
  assign err_v = q_big ? (clk_r - {prod_r[CW-DW-1:0], {DW{1'b0}}})
                       : CW'(div_rsp.remainder);

  always_comb begin
    state_nxt     = state_r;
    scl_nxt       = scl_r;
    have_nxt      = have_r;
    out_valid_nxt = out_valid_r;
    rate_nxt      = rate_r;
    clk_nxt       = clk_r;
    prod_nxt      = prod_r;
    best_div_nxt  = best_div_r;
    kept_scl_nxt  = kept_scl_r;
    best_err_nxt  = best_err_r;
    out_div_nxt   = out_div_r;
    out_scl_nxt   = out_scl_r;
    out_err_nxt   = out_err_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          rate_nxt  = in_ch.bit_rate;
          clk_nxt   = in_ch.source_clock;
          prod_nxt  = {1'b0, in_ch.bit_rate, 4'b0000}
                    + {4'b0000, in_ch.bit_rate, 1'b0};
          scl_nxt   = i2cbd_pkg::SCL_FIRST;
          have_nxt  = 1'b0;
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (div_rsp.done) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (!have_r || (err_v < best_err_r)) begin
          best_div_nxt = div_v;
          kept_scl_nxt = scl_r;
          best_err_nxt = err_v;
          have_nxt     = 1'b1;
        end
        if ((err_v == '0) || q_big || (scl_r == i2cbd_pkg::SCL_LAST)) begin
          state_nxt = ST_FIN;
        end else begin
          scl_nxt   = scl_r - 4'd1;
          prod_nxt  = prod_r - {4'b0000, rate_r, 1'b0};
          state_nxt = ST_START;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_div_nxt   = best_div_r - DW'(1);
          out_scl_nxt   = i2cbd_pkg::SCL_W'(kept_scl_r - i2cbd_pkg::SCL_LAST);
          out_err_nxt   = best_err_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
      scl_r       <= i2cbd_pkg::SCL_FIRST;
    end else begin
      state_r     <= state_nxt;
      have_r      <= have_nxt;
      out_valid_r <= out_valid_nxt;
      scl_r       <= scl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rate_r     <= rate_nxt;
    clk_r      <= clk_nxt;
    prod_r     <= prod_nxt;
    best_div_r <= best_div_nxt;
    kept_scl_r <= kept_scl_nxt;
    best_err_r <= best_err_nxt;
    out_div_r  <= out_div_nxt;
    out_scl_r  <= out_scl_nxt;
    out_err_r  <= out_err_nxt;
  end

  assign in_ch.ready           = (state_r == ST_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.divider_field  = out_div_r;
  assign out_ch.scl_time_field = out_scl_r;
  assign out_ch.residual_error = out_err_r;

`ifndef ASSERT_OFF
  a_scl_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (scl_r >= i2cbd_pkg::SCL_LAST && scl_r <= i2cbd_pkg::SCL_FIRST))
    else $error("SCL count left the search range.");
  a_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ST_RUN))
    else $error("Divider finished outside the run state.");
  a_fin_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && out_free) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("Finished search did not present a result beat.");
  a_best_after_eval: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EVAL) |=> have_r)
    else $error("Evaluation did not record a candidate.");
`endif

endmodule
`default_nettype wire
